/* rtl/core/tdce_pkg.sv */
// Shared constants, codes and control structs for the text display char engine.
// No dependencies; every other file of the block but tdce_ram uses this package.
package tdce_pkg;

    localparam int BUF_SIZE  = 2048;
    localparam int ADDR_W    = $clog2(BUF_SIZE);
    localparam int CNT_W     = $clog2(BUF_SIZE + 1);
    localparam int SRC_W     = CNT_W + 9;
    localparam int CLIM      = (BUF_SIZE < 4095) ? BUF_SIZE : 4095;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int IN_ADDR_W = 11;
    localparam int POS_W     = 12;
    localparam int ROW_W     = 8;
    localparam int COL_W     = 12;
    localparam int UPD_W     = 16;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = 2 * CFG_W;

    localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
    localparam logic [OP_W-1:0] OP_CMD  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS     = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CMD_CLEAR = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

    localparam logic [CFG_W-1:0] COLUMNS_RST = 8'd80;
    localparam logic [CFG_W-1:0] ROWS_RST    = 8'd25;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rowstart;
        logic clear_step;
        logic scroll_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_cr;
        logic is_lf;
        logic is_clear;
        logic lf_scroll;
        logic clear_last;
        logic scroll_last;
    } dp_status_t;

endpackage

/* rtl/core/tdce_item_if.sv */
// Input channel: valid/ready handshake carrying one op, data and address.
// Depends on tdce_pkg for field widths.
interface tdce_item_if;
    logic                               valid;
    logic                               ready;
    logic [tdce_pkg::OP_W-1:0]          op;
    logic [tdce_pkg::CHAR_W-1:0]        data;
    logic [tdce_pkg::IN_ADDR_W-1:0]     address;

    modport source (output valid, output op, output data, output address, input ready);
    modport sink   (input valid, input op, input data, input address, output ready);
endinterface

/* rtl/core/tdce_result_if.sv */
// Output channel: valid/ready handshake carrying the cell read and cursor state.
// Depends on tdce_pkg for field widths.
interface tdce_result_if;
    logic                           valid;
    logic                           ready;
    logic [tdce_pkg::CHAR_W-1:0]    read_data;
    logic [tdce_pkg::POS_W-1:0]     cursor;
    logic [tdce_pkg::ROW_W-1:0]     row;
    logic [tdce_pkg::COL_W-1:0]     col;
    logic [tdce_pkg::UPD_W-1:0]     update_count;

    modport source (output valid, output read_data, output cursor, output row, output col,
                    output update_count, input ready);
    modport sink   (input valid, input read_data, input cursor, input row, input col,
                    input update_count, output ready);
endinterface

/* rtl/core/tdce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/core/tdce_datapath.sv */
// Datapath: config registers, cursor state, screen RAM, sweep counter, result register.
// Depends on tdce_pkg and tdce_ram; driven by commands from tdce_ctrl.
module tdce_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tdce_pkg::dp_cmd_t               cmd,
    output tdce_pkg::dp_status_t            status,
    input  logic [tdce_pkg::OP_W-1:0]       op,
    input  logic [tdce_pkg::CHAR_W-1:0]     data,
    input  logic [tdce_pkg::IN_ADDR_W-1:0]  address,
    input  logic                            config_we,
    input  logic [tdce_pkg::CFG_IDX_W-1:0]  config_index,
    input  logic [tdce_pkg::CFG_W-1:0]      config_data,
    output logic [tdce_pkg::CHAR_W-1:0]     read_data,
    output logic [tdce_pkg::POS_W-1:0]      cursor,
    output logic [tdce_pkg::ROW_W-1:0]      row,
    output logic [tdce_pkg::COL_W-1:0]      col,
    output logic [tdce_pkg::UPD_W-1:0]      update_count
);
    import tdce_pkg::*;

    logic [OP_W-1:0]      op_reg;
    logic [CHAR_W-1:0]    data_reg;
    logic [IN_ADDR_W-1:0] addr_reg;

    logic [CFG_W-1:0]     columns_reg;
    logic [CFG_W-1:0]     rows_reg;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [UPD_W-1:0]     upd_reg, upd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 src_ok_reg, src_ok_next;
    logic                 rd_ok_reg, rd_ok_next;

    logic [CHAR_W-1:0]    rd_out_reg;
    logic [POS_W-1:0]     pos_out_reg;
    logic [ROW_W-1:0]     row_out_reg;
    logic [COL_W-1:0]     col_out_reg;
    logic [UPD_W-1:0]     upd_out_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [CHAR_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [CHAR_W-1:0]    ram_rdata;

    logic                 is_char;
    logic                 is_bs;
    logic [ROW_W:0]       row_inc;
    logic [POS_W-1:0]     pos_dec;
    logic [PROD_W-1:0]    prod;
    logic [POS_W-1:0]     rowstart_pos;
    logic [SRC_W-1:0]     src;
    logic                 src_ok;
    logic [CNT_W-1:0]     wr_idx;

    tdce_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUF_SIZE)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign is_char      = (op_reg == OP_CHAR);
    assign is_bs        = is_char && (data_reg == CH_BS);
    assign row_inc      = {1'b0, row_reg} + (ROW_W + 1)'(1);
    assign pos_dec      = pos_reg - POS_W'(1);
    assign prod         = PROD_W'(row_reg) * PROD_W'(columns_reg);
    assign rowstart_pos = (prod > PROD_W'(CLIM)) ? POS_W'(CLIM) : POS_W'(prod);
    assign src          = SRC_W'(cnt_reg) + SRC_W'(columns_reg);
    assign src_ok       = (src < SRC_W'(BUF_SIZE));
    assign wr_idx       = cnt_reg - CNT_W'(1);

    assign status.is_cr       = is_char && (data_reg == CH_CR);
    assign status.is_lf       = is_char && (data_reg == CH_LF);
    assign status.is_clear    = (op_reg == OP_CMD) && (data_reg == CMD_CLEAR);
    assign status.lf_scroll   = (row_inc == {1'b0, rows_reg});
    assign status.clear_last  = (cnt_reg == CNT_W'(BUF_SIZE - 1));
    assign status.scroll_last = (cnt_reg == CNT_W'(BUF_SIZE));

    always_comb
    begin
        pos_next    = pos_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        upd_next    = upd_reg;
        cnt_next    = cnt_reg;
        src_ok_next = src_ok_reg;
        rd_ok_next  = rd_ok_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = CH_SPACE;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(cnt_reg);
            cnt_next  = cnt_reg + CNT_W'(1);
        end

        // scroll: read cell k+columns while writing cell k-1 with last cycle's read
        if (cmd.scroll_step)
        begin
            ram_re      = src_ok && !status.scroll_last;
            ram_raddr   = ADDR_W'(src);
            ram_we      = (cnt_reg != '0);
            ram_waddr   = ADDR_W'(wr_idx);
            ram_wdata   = src_ok_reg ? ram_rdata : CH_SPACE;
            src_ok_next = src_ok;
            cnt_next    = cnt_reg + CNT_W'(1);
        end

        if (cmd.rowstart)
        begin
            pos_next = rowstart_pos;
        end

        if (cmd.exec)
        begin
            cnt_next    = '0;
            src_ok_next = 1'b0;
            rd_ok_next  = 1'b0;
            unique case (op_reg)
                OP_CHAR:
                begin
                    upd_next = upd_reg + UPD_W'(1);
                    if (is_bs)
                    begin
                        if (col_reg != '0)
                        begin
                            col_next  = col_reg - COL_W'(1);
                            pos_next  = pos_dec;
                            ram_we    = (32'(pos_dec) < BUF_SIZE);
                            ram_waddr = ADDR_W'(pos_dec);
                            ram_wdata = CH_SPACE;
                        end
                    end
                    else if (status.is_cr)
                    begin
                        col_next = '0;
                    end
                    else if (status.is_lf)
                    begin
                        col_next = '0;
                        if (!status.lf_scroll)
                        begin
                            row_next = row_inc[ROW_W] ? '1 : row_inc[ROW_W-1:0];
                        end
                    end
                    else if (pos_reg < POS_W'(CLIM))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(pos_reg);
                        ram_wdata = data_reg;
                        pos_next  = pos_reg + POS_W'(1);
                        col_next  = col_reg + COL_W'(1);
                    end
                end
                OP_CMD:
                begin
                    if (status.is_clear)
                    begin
                        pos_next = '0;
                        row_next = '0;
                        col_next = '0;
                    end
                end
                OP_READ:
                begin
                    rd_ok_next = (32'(addr_reg) < BUF_SIZE);
                    ram_re     = 1'b1;
                    ram_raddr  = ADDR_W'(addr_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            data_reg <= data;
            addr_reg <= address;
        end
        if (cmd.out_load)
        begin
            rd_out_reg  <= ((op_reg == OP_READ) && rd_ok_reg) ? ram_rdata : '0;
            pos_out_reg <= pos_reg;
            row_out_reg <= row_reg;
            col_out_reg <= col_reg;
            upd_out_reg <= upd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RST;
            rows_reg    <= ROWS_RST;
            pos_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            upd_reg     <= '0;
            cnt_reg     <= '0;
            src_ok_reg  <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (config_we)
            begin
                unique case (config_index)
                    REG_COLUMNS: columns_reg <= config_data;
                    REG_ROWS:    rows_reg    <= config_data;
                    default:
                    begin
                    end
                endcase
            end
            pos_reg    <= pos_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            upd_reg    <= upd_next;
            cnt_reg    <= cnt_next;
            src_ok_reg <= src_ok_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    assign read_data    = rd_out_reg;
    assign cursor       = pos_out_reg;
    assign row          = row_out_reg;
    assign col          = col_out_reg;
    assign update_count = upd_out_reg;

    a_upd_char: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && is_char) |=> (upd_reg == $past(upd_reg) + UPD_W'(1)))
        else $error("update count did not advance on a character");

    a_upd_other: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && !is_char) |=> (upd_reg == $past(upd_reg)))
        else $error("update count moved on a non-character transaction");

endmodule

/* rtl/core/tdce_ctrl.sv */
// Controller FSM: sequences capture, execute, row start, scroll and clear sweeps.
// Depends on tdce_pkg; drives tdce_datapath through dp_cmd_t.
module tdce_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  tdce_pkg::dp_status_t  status,
    output tdce_pkg::dp_cmd_t     cmd
);
    import tdce_pkg::*;

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_EXEC     = 3'd2;
    localparam logic [2:0] S_ROWSTART = 3'd3;
    localparam logic [2:0] S_SCROLL   = 3'd4;
    localparam logic [2:0] S_CLEAR    = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;

        unique case (state_reg)
            S_INIT:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (status.is_lf)
                begin
                    state_next = status.lf_scroll ? S_SCROLL : S_ROWSTART;
                end
                else if (status.is_cr)
                begin
                    state_next = S_ROWSTART;
                end
                else if (status.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ROWSTART:
            begin
                cmd.rowstart = 1'b1;
                state_next   = S_DONE;
            end
            S_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (status.scroll_last)
                begin
                    state_next = S_ROWSTART;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == S_EXEC))
        else $error("accepted transaction not executed");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || result_ready)) |=> out_valid_reg)
        else $error("result load did not raise valid");

    a_scroll_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL && status.scroll_last) |=> (state_reg == S_ROWSTART))
        else $error("scroll sweep did not end in row start");

endmodule

/* rtl/core/text_display_char_engine.sv */
// Text display char engine top: joins controller, datapath and channel interfaces.
// Accept to result valid: EXEC then DONE; CR and LF add ROWSTART before DONE, LF with scroll
// adds SCROLL before ROWSTART, clear adds the CLEAR sweep. One transaction in flight;
// a new item is taken only in IDLE. Scroll and clear sweep the screen RAM one cell per cycle.
// Reset: async active low; a pass fills the screen with spaces, no accept meanwhile.
// Depends on tdce_pkg, tdce_item_if, tdce_result_if, tdce_ctrl, tdce_datapath.
module text_display_char_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    tdce_item_if.sink                       item,
    tdce_result_if.source                   result,
    input  logic                            config_we,
    input  logic [tdce_pkg::CFG_IDX_W-1:0]  config_index,
    input  logic [tdce_pkg::CFG_W-1:0]      config_data
);
    import tdce_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tdce_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    tdce_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (item.op),
        .data         (item.data),
        .address      (item.address),
        .config_we    (config_we),
        .config_index (config_index),
        .config_data  (config_data),
        .read_data    (result.read_data),
        .cursor       (result.cursor),
        .row          (result.row),
        .col          (result.col),
        .update_count (result.update_count)
    );

endmodule
